>>> rtl/b64d_pkg.sv
// shared types, constants and the character decode function for the base64 decoder
`default_nettype none
package b64d_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] PAD_CHAR     = 8'h3D;
   localparam logic [6:0] SEXTET_BAD   = 7'd64;

   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_THIRD  = 2'd2;
   localparam logic [1:0] POS_FOURTH = 2'd3;

   // one decoded request as handed from the front to the back
   typedef struct packed {
      logic [2:0][7:0] bytes;       // bytes[0] goes out first
      logic [1:0]      n_bytes;     // 0 means bare end marker
      logic            chunk_end;
      logic            halted;
   } job_type;

   // 0..63 for an alphabet character, SEXTET_BAD otherwise
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [6:0] v;
      v = SEXTET_BAD;
      if (c >= 8'h41 && c <= 8'h5A) begin
         v = 7'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         v = 7'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = 7'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         v = 7'd62;
      end else if (c == 8'h2F) begin
         v = 7'd63;
      end
      return v;
   endfunction

endpackage
`default_nettype wire

>>> rtl/b64d_front.sv
// front end: classifies each character, keeps the group state and builds decode jobs
`default_nettype none
module b64d_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       in_char,
   input  wire logic             chunk_end,
   output logic                  job_push,
   output b64d_pkg::job_type     job
);
   import b64d_pkg::*;

   logic [1:0]      pos_ff, pos_in;
   logic [2:0][5:0] sext_ff, sext_in;
   logic            third_pad_ff, third_pad_in;
   logic            halted_ff, halted_in;

   logic            pad;
   logic [6:0]      v;
   logic [1:0]      n;
   logic [2:0][7:0] bytes;

   always_comb begin
      pos_in       = pos_ff;
      sext_in      = sext_ff;
      third_pad_in = third_pad_ff;
      halted_in    = halted_ff;
      n            = 2'd0;
      bytes        = '0;
      pad          = (in_char == PAD_CHAR) && (pos_ff == POS_THIRD || pos_ff == POS_FOURTH);
      v            = pad ? 7'd0 : sextet_of(in_char);

      if (!halted_ff) begin
         if (v == SEXTET_BAD) begin
            halted_in = 1'b1;
         end else if (pos_ff != POS_FOURTH) begin
            sext_in[pos_ff] = v[5:0];
            if (pos_ff == POS_THIRD) begin
               third_pad_in = pad;
            end
            pos_in = pos_ff + 2'd1;
         end else begin
            // pack the group, skipping bytes that fall under padding
            bytes[0] = {sext_ff[0], sext_ff[1][5:4]};
            n        = 2'd1;
            if (!third_pad_ff) begin
               bytes[n] = {sext_ff[1][3:0], sext_ff[2][5:2]};
               n        = n + 2'd1;
            end
            if (!pad) begin
               bytes[n] = {sext_ff[2][1:0], v[5:0]};
               n        = n + 2'd1;
            end
            pos_in       = POS_FIRST;
            sext_in      = '0;
            third_pad_in = 1'b0;
         end
      end

      job.bytes     = bytes;
      job.n_bytes   = n;
      job.chunk_end = chunk_end;
      job.halted    = halted_in;
      job_push      = accept && (n != 2'd0 || chunk_end);

      if (chunk_end) begin
         pos_in       = POS_FIRST;
         sext_in      = '0;
         third_pad_in = 1'b0;
         halted_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_FIRST;
         sext_ff      <= '0;
         third_pad_ff <= 1'b0;
         halted_ff    <= 1'b0;
      end else if (accept) begin
         pos_ff       <= pos_in;
         sext_ff      <= sext_in;
         third_pad_ff <= third_pad_in;
         halted_ff    <= halted_in;
      end
   end

   // a padded third character is only remembered while waiting for the fourth
   a_third_pad_pos: assert property (@(posedge clock) disable iff (reset)
      third_pad_ff |-> pos_ff == POS_FOURTH)
      else $error("third pad flag set outside fourth position");

endmodule
`default_nettype wire

>>> rtl/b64d_queue.sv
// short job queue between the front and the back
`default_nettype none
module b64d_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire b64d_pkg::job_type push_job,
   input  wire logic             pop,
   output logic                  full,
   output logic                  empty,
   output b64d_pkg::job_type     head
);
   import b64d_pkg::*;

   job_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push, do_pop;

   always_comb begin
      full    = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
      empty   = (cnt_ff == '0);
      do_push = push && !full;
      do_pop  = pop && !empty;
      wr_in   = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in   = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in  = cnt_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
      head    = entry_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("job pushed into full queue");

endmodule
`default_nettype wire

>>> rtl/b64d_back.sv
// back end: walks the head job one result at a time
`default_nettype none
module b64d_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire b64d_pkg::job_type head,
   input  wire logic             q_empty,
   input  wire logic             rsp_pop,
   output logic                  job_pop,
   output logic [7:0]            out_byte,
   output logic                  byte_valid,
   output logic                  last_of_run,
   output logic                  chunk_done,
   output logic                  decode_halted
);
   import b64d_pkg::*;

   logic [1:0] k_ff, k_in;
   logic [1:0] total;
   logic       last;

   always_comb begin
      total         = (head.n_bytes == 2'd0) ? 2'd1 : head.n_bytes;
      last          = (k_ff == total - 2'd1);
      byte_valid    = (k_ff < head.n_bytes);
      case (k_ff)
         2'd0:    out_byte = head.bytes[0];
         2'd1:    out_byte = head.bytes[1];
         2'd2:    out_byte = head.bytes[2];
         default: out_byte = 8'd0;
      endcase
      if (!byte_valid) begin
         out_byte = 8'd0;
      end
      last_of_run   = last;
      chunk_done    = last && head.chunk_end;
      decode_halted = head.halted;
      job_pop       = rsp_pop && !q_empty && last;
      k_in          = k_ff;
      if (rsp_pop && !q_empty) begin
         k_in = last ? 2'd0 : k_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= 2'd0;
      end else begin
         k_ff <= k_in;
      end
   end

   // the result index never runs past the head job's result count
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> k_ff < total)
      else $error("result index beyond job");

endmodule
`default_nettype wire

>>> rtl/base64_stream_decoder.sv
// top level of the streaming base64 decoder
// a request's job is registered in the job queue; its results show on the rsp_ ports once that job is at the head
// throughput: one request per cycle while the four-entry job queue has room
// results leave one per cycle while pop is high and the queue is not empty; a request yields zero to three results
// reset clears group state, halt flag and the job queue; pending results are dropped
`default_nettype none
module base64_stream_decoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire logic [7:0] req_in_char,
   input  wire logic       req_chunk_end,
   output logic            empty,
   input  wire logic       pop,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_byte_valid,
   output logic            rsp_last_of_run,
   output logic            rsp_chunk_done,
   output logic            rsp_decode_halted
);
   import b64d_pkg::*;

   logic    accept;
   logic    job_push;
   logic    job_pop;
   job_type job;
   job_type head;

   assign accept = push && !full;

   b64d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_char   (req_in_char),
      .chunk_end (req_chunk_end),
      .job_push  (job_push),
      .job       (job)
   );

   b64d_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job),
      .pop      (job_pop),
      .full     (full),
      .empty    (empty),
      .head     (head)
   );

   b64d_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .q_empty       (empty),
      .rsp_pop       (pop),
      .job_pop       (job_pop),
      .out_byte      (rsp_out_byte),
      .byte_valid    (rsp_byte_valid),
      .last_of_run   (rsp_last_of_run),
      .chunk_done    (rsp_chunk_done),
      .decode_halted (rsp_decode_halted)
   );

endmodule
`default_nettype wire
